// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/i2p_pkg.sv
// Package for the infix to postfix converter: character codes, precedence,
// character classes and the sequencer state type. No dependencies.
package i2p_pkg;

  localparam int I2P_STACK_DEPTH = 32;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_UNMATCH = 2'd2,
    ERR_UNKNOWN = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLOSE,
    S_OPPOP,
    S_FLUSH,
    S_FIN
  } state_e;

  // 0 means not an operator
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// File: hw/rtl/infix_to_postfix_converter.sv
// Infix to postfix converter, top level: sequencer, operator stack memory,
// pending result slot and output register. Uses i2p_pkg and assert_macros.svh.
//
// Takes one ASCII character per word and emits the postfix form (shunting
// yard, + - below * / below ^, all left-associative). Each input word gives
// one or more result words; run_last marks the last of them, expr_done marks
// it too when the input word had expr_end set, which also flushes the stack.
// A word that emits nothing still gives one status-only result. Errors
// (stack full, unmatched ')', unknown character) come as status-only results.
// Sequencing: the block takes one word at a time and holds in_stall_o high until
// its last result is in the output register. An alphanumeric, '(' or unknown
// character passes through the decode and finish states; ')' and operators
// also pass through the close or operator-pop state, popping one operator at a
// time, and expr_end adds the flush state to pop the entries left. The stack
// has one read port and the precedence compare pops a single entry per cycle,
// held while the output side stalls. The stack needs no clearing after reset.
`include "assert_macros.svh"

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = I2P_STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       expr_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_symbol_o,
  output logic       has_symbol_o,
  output logic       run_last_o,
  output logic       expr_done_o,
  output logic [1:0] error_code_o
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  state_e state_q, state_d;

  // input word held for the duration of the run
  logic [7:0] sym_q;
  logic       last_q;

  // stack: entries in memory, copy of the top entry in top_q
  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       top_q;
  logic [CNT_W-1:0] rd_ptr;

  // pending result: held back until we know whether it is the last one
  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_sym_q;
  logic       pend_has_q;
  err_e       pend_err_q;

  // output register
  logic       out_v_q, out_v_d;
  logic [7:0] out_sym_q;
  logic       out_has_q, out_last_q, out_done_q;
  err_e       out_err_q;

  // sequencer actions
  logic       want_emit, go, push, pop, fin;
  logic [7:0] emit_sym;
  logic       emit_has;
  err_e       emit_err;
  logic       out_free, can_emit, accept, full, empty;
  state_e     after_item;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign full       = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty      = (cnt_q == '0);
  assign out_free   = !out_v_q || !out_stall_i;
  // a new result only displaces the pending one if the output can take it
  assign can_emit   = !pend_v_q || out_free;
  assign after_item = last_q ? S_FLUSH : S_FIN;
  assign rd_ptr     = cnt_q - CNT_W'(2);

  always_comb begin
    state_d   = state_q;
    want_emit = 1'b0;
    emit_sym  = 8'h00;
    emit_has  = 1'b0;
    emit_err  = ERR_NONE;
    push      = 1'b0;
    pop       = 1'b0;
    fin       = 1'b0;
    go        = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (is_alnum(sym_q)) begin
          want_emit = 1'b1;
          emit_sym  = sym_q;
          emit_has  = 1'b1;
          state_d   = after_item;
        end else if (sym_q == CH_LPAREN) begin
          if (full) begin
            want_emit = 1'b1;
            emit_err  = ERR_FULL;
          end else begin
            push = 1'b1;
          end
          state_d = after_item;
        end else if (sym_q == CH_RPAREN) begin
          state_d = S_CLOSE;
        end else if (prec_of(sym_q) != 2'd0) begin
          state_d = S_OPPOP;
        end else begin
          want_emit = 1'b1;
          emit_err  = ERR_UNKNOWN;
          state_d   = after_item;
        end
      end
      S_CLOSE: begin
        if (empty) begin
          want_emit = 1'b1;
          emit_err  = ERR_UNMATCH;
          state_d   = after_item;
        end else if (top_q == CH_LPAREN) begin
          pop     = 1'b1;
          state_d = after_item;
        end else begin
          want_emit = 1'b1;
          emit_sym  = top_q;
          emit_has  = 1'b1;
          pop       = 1'b1;
        end
      end
      S_OPPOP: begin
        // pop while top is an operator of equal or higher precedence
        if (!empty && (prec_of(top_q) != 2'd0) && (prec_of(top_q) >= prec_of(sym_q))) begin
          want_emit = 1'b1;
          emit_sym  = top_q;
          emit_has  = 1'b1;
          pop       = 1'b1;
        end else begin
          if (full) begin
            want_emit = 1'b1;
            emit_err  = ERR_FULL;
          end else begin
            push = 1'b1;
          end
          state_d = after_item;
        end
      end
      S_FLUSH: begin
        if (empty) begin
          state_d = S_FIN;
        end else begin
          // stray '(' is dropped silently
          want_emit = (top_q != CH_LPAREN);
          emit_sym  = top_q;
          emit_has  = 1'b1;
          pop       = 1'b1;
        end
      end
      S_FIN: begin
        fin = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (want_emit && !can_emit) begin
      go      = 1'b0;
      push    = 1'b0;
      pop     = 1'b0;
      state_d = state_q;
    end
  end

  // stack count and pending slot
  always_comb begin
    cnt_d = cnt_q;
    if (push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    pend_v_d = pend_v_q;
    if (fin) begin
      pend_v_d = 1'b0;
    end else if (want_emit && go) begin
      pend_v_d = 1'b1;
    end
  end

  // output register: loaded when a pending result is displaced or at the end
  always_comb begin
    out_v_d = out_v_q && out_stall_i;
    if (fin || (want_emit && go && pend_v_q)) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= symbol_i;
      last_q <= expr_end_i;
    end
    if (want_emit && go) begin
      pend_sym_q <= emit_sym;
      pend_has_q <= emit_has;
      pend_err_q <= emit_err;
    end
    if (fin) begin
      out_sym_q  <= pend_v_q ? pend_sym_q : 8'h00;
      out_has_q  <= pend_v_q && pend_has_q;
      out_err_q  <= pend_v_q ? pend_err_q : ERR_NONE;
      out_last_q <= 1'b1;
      out_done_q <= last_q;
    end else if (want_emit && go && pend_v_q) begin
      out_sym_q  <= pend_sym_q;
      out_has_q  <= pend_has_q;
      out_err_q  <= pend_err_q;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end
  end

  // stack memory, single write port and one registered read into top_q
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[ADDR_W-1:0]] <= sym_q;
      top_q                        <= sym_q;
    end else if (pop) begin
      top_q <= stack_mem[rd_ptr[ADDR_W-1:0]];
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_symbol_o = out_sym_q;
  assign has_symbol_o = out_has_q;
  assign run_last_o   = out_last_q;
  assign expr_done_o  = out_done_q;
  assign error_code_o = out_err_q;

  `ASSERT_IMPLIES(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH))
  `ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, accept, state_q == S_DECODE)
  `ASSERT_NEXT(a_fin_last, clk_i, rst_ni, fin,
               state_q == S_IDLE && out_v_q && out_last_q && !pend_v_q)
  `ASSERT_IMPLIES(a_err_no_sym, clk_i, rst_ni, out_v_q && out_has_q, out_err_q == ERR_NONE)

endmodule
